// ===== design/t2u_pkg.sv =====
// t2u_pkg: shared types, character codes and helpers for the text to u64 parser
// no dependencies; used by t2u_digit and text_to_u64_parser
package t2u_pkg;

	localparam int CharW = 32;

	localparam logic [CharW-1:0] ChZero = 32'h30;
	localparam logic [CharW-1:0] ChNine = 32'h39;
	localparam logic [CharW-1:0] ChLowA = 32'h61;
	localparam logic [CharW-1:0] ChLowF = 32'h66;
	localparam logic [CharW-1:0] ChUpA  = 32'h41;
	localparam logic [CharW-1:0] ChUpF  = 32'h46;
	localparam logic [CharW-1:0] ChLowX = 32'h78;
	localparam logic [CharW-1:0] ChUpX  = 32'h58;
	localparam logic [CharW-1:0] ChTab  = 32'h09;
	localparam logic [CharW-1:0] ChCr   = 32'h0D;
	localparam logic [CharW-1:0] ChSp   = 32'h20;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_INVALID   = 2'd2,
		ST_TOO_LARGE = 2'd3
	} status_t;

	typedef struct packed {
		logic is_digit;
		logic overflow;
	} digit_flags_t;

	function automatic logic is_space(input logic [CharW-1:0] c);
		return ((c >= ChTab) && (c <= ChCr)) || (c == ChSp);
	endfunction

endpackage

// ===== design/t2u_digit.sv =====
// t2u_digit: decodes one digit character and forms acc * base + digit
// depends on t2u_pkg for character codes and the flag struct
module t2u_digit (
	input  logic [t2u_pkg::CharW-1:0] c,
	input  logic                      hex,
	input  logic [63:0]               acc,
	output logic [63:0]               acc_next,
	output t2u_pkg::digit_flags_t     flags
);

	logic [3:0]  d;
	logic        is_dig;
	logic [67:0] prod;
	logic [67:0] sum;

	always_comb begin
		d      = 4'd0;
		is_dig = 1'b1;
		if ((c >= t2u_pkg::ChZero) && (c <= t2u_pkg::ChNine)) begin
			d = 4'(c - t2u_pkg::ChZero);
		end else if (hex && (c >= t2u_pkg::ChLowA) && (c <= t2u_pkg::ChLowF)) begin
			d = 4'(c - t2u_pkg::ChLowA) + 4'd10;
		end else if (hex && (c >= t2u_pkg::ChUpA) && (c <= t2u_pkg::ChUpF)) begin
			d = 4'(c - t2u_pkg::ChUpA) + 4'd10;
		end else begin
			is_dig = 1'b0;
		end
	end

	// times 16 is a shift, times 10 is 8x + 2x
	assign prod = hex ? {acc, 4'b0000} : ({1'b0, acc, 3'b000} + {3'b000, acc, 1'b0});
	assign sum  = prod + {64'd0, d};

	assign flags    = '{is_digit: is_dig, overflow: |sum[67:64]};
	assign acc_next = sum[63:0];

endmodule

// ===== design/text_to_u64_parser.sv =====
// text_to_u64_parser: streaming decimal / hex text to unsigned 64-bit parser
// depends on t2u_pkg and t2u_digit
// timing: an item is registered in the input stage and processed from there;
// the result of the last item of a string is registered in the output stage
// throughput: one item per cycle; a last item waits while an unread result is held
// reset: arst_n clears the input valid flag, the output stage and the parse state
module text_to_u64_parser #(
	parameter int CHAR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CHAR_BITS-1:0] ch,
	input  logic                 has_char,
	input  logic                 is_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [63:0]          value,
	output logic [1:0]           status
);

	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_ZERO   = 3'd1,
		PH_ZEROX  = 3'd2,
		PH_DIGITS = 3'd3,
		PH_TRAIL  = 3'd4
	} phase_t;

	logic                 valid_s1;
	logic [CHAR_BITS-1:0] ch_s1;
	logic                 has_char_s1;
	logic                 is_last_s1;

	phase_t               phase_q, phase_d;
	logic [63:0]          acc_q, acc_d;
	logic                 hex_q, hex_d;
	t2u_pkg::status_t     err_q, err_d;

	logic                 out_valid_q;
	logic [63:0]          value_q;
	t2u_pkg::status_t     status_q;

	logic                      advance;
	logic [t2u_pkg::CharW-1:0] c;
	logic                      hex_eff;
	logic [63:0]               dig_acc;
	t2u_pkg::digit_flags_t     dig_flags;
	logic                      sp;
	t2u_pkg::status_t          res_status;
	logic [63:0]               res_value;

	assign advance  = valid_s1 && (!is_last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1       <= ch;
			has_char_s1 <= has_char;
			is_last_s1  <= is_last;
		end
	end

	assign c       = t2u_pkg::CharW'(ch_s1);
	assign sp      = t2u_pkg::is_space(c);
	assign hex_eff = (phase_q == PH_ZEROX) ? 1'b1 : hex_q;

	t2u_digit u_digit (
		.c        (c),
		.hex      (hex_eff),
		.acc      (acc_q),
		.acc_next (dig_acc),
		.flags    (dig_flags)
	);

	always_comb begin
		logic take;
		take    = 1'b0;
		phase_d = phase_q;
		acc_d   = acc_q;
		hex_d   = hex_q;
		err_d   = err_q;
		if (has_char_s1 && (err_q == t2u_pkg::ST_OK)) begin
			unique case (phase_q)
				PH_LEAD: begin
					if (c == t2u_pkg::ChZero) begin
						phase_d = PH_ZERO;
						acc_d   = 64'd0;
					end else if (!sp) begin
						phase_d = PH_DIGITS;
						take    = 1'b1;
					end
				end
				PH_ZERO: begin
					if ((c == t2u_pkg::ChLowX) || (c == t2u_pkg::ChUpX)) begin
						phase_d = PH_ZEROX;
					end else if (sp) begin
						phase_d = PH_TRAIL;
					end else begin
						phase_d = PH_DIGITS;
						take    = 1'b1;
					end
				end
				PH_ZEROX: begin
					if (sp) begin
						err_d = t2u_pkg::ST_INVALID;
					end else begin
						hex_d   = 1'b1;
						phase_d = PH_DIGITS;
						take    = 1'b1;
					end
				end
				PH_TRAIL: begin
					if (!sp) begin
						err_d = t2u_pkg::ST_INVALID;
					end
				end
				default: begin
					if (sp) begin
						phase_d = PH_TRAIL;
					end else begin
						take = 1'b1;
					end
				end
			endcase
			if (take) begin
				if (!dig_flags.is_digit) begin
					err_d = t2u_pkg::ST_INVALID;
				end else if (dig_flags.overflow) begin
					err_d = t2u_pkg::ST_TOO_LARGE;
				end else begin
					acc_d = dig_acc;
				end
			end
		end
		res_value = 64'd0;
		if (err_d != t2u_pkg::ST_OK) begin
			res_status = err_d;
		end else if (phase_d == PH_LEAD) begin
			res_status = t2u_pkg::ST_EMPTY;
		end else if (phase_d == PH_ZEROX) begin
			res_status = t2u_pkg::ST_INVALID;
		end else begin
			res_status = t2u_pkg::ST_OK;
			res_value  = acc_d;
		end
	end

	// parse state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			acc_q       <= 64'd0;
			hex_q       <= 1'b0;
			err_q       <= t2u_pkg::ST_OK;
			out_valid_q <= 1'b0;
			value_q     <= 64'd0;
			status_q    <= t2u_pkg::ST_OK;
		end else begin
			if (out_ready && !(advance && is_last_s1)) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (is_last_s1) begin
					phase_q     <= PH_LEAD;
					acc_q       <= 64'd0;
					hex_q       <= 1'b0;
					err_q       <= t2u_pkg::ST_OK;
					out_valid_q <= 1'b1;
					value_q     <= res_value;
					status_q    <= res_status;
				end else begin
					phase_q <= phase_d;
					acc_q   <= acc_d;
					hex_q   <= hex_d;
					err_q   <= err_d;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_last_s1 |=> (phase_q == PH_LEAD) && (err_q == t2u_pkg::ST_OK) && !hex_q)
		else $error("parse state not cleared after last item");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != t2u_pkg::ST_OK) |-> (value_q == 64'd0))
		else $error("value nonzero with error status");

	a_hex_phase: assert property (@(posedge clk) disable iff (!arst_n)
		hex_q |-> (phase_q == PH_DIGITS) || (phase_q == PH_TRAIL))
		else $error("hex mode outside digits or trailing phase");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(ch_s1) && $stable(is_last_s1))
		else $error("stalled input stage lost its item");

endmodule
